/* hw/rtl/mfb_pkg.sv */
// Shared types, register codes and CRC-32 helper for the MAC frame builder.
`timescale 1ns / 1ps
package mfb_pkg;

	localparam int HDR_LEN = 24;
	localparam int HDR_IDX_W = 5;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDR   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_ADDR  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_THIRD_ADDR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_CTRL = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQ_NUM    = 3'd4;

	localparam logic [47:0] OWN_ADDR_RST   = 48'h0000_0000_0000;
	localparam logic [47:0] DEST_ADDR_RST  = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] THIRD_ADDR_RST = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] FRAME_CTRL_RST = 16'h2900;
	localparam logic [15:0] SEQ_NUM_RST    = 16'h0000;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} out_word_t;

	// front -> back command
	typedef struct packed {
		logic [7:0] data;
		logic       hdr;
		logic       keep;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [47:0] own_address;
		logic [47:0] dest_address;
		logic [47:0] third_address;
		logic [15:0] ctrl_word;
		logic [15:0] sequence_number;
	} hdr_cfg_t;

	typedef enum logic [1:0] {
		PH_NEW,
		PH_HDR,
		PH_PAY,
		PH_FCS
	} phase_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/mfb_fifo.sv */
// Small register-based FIFO used for the command and result queues.
`timescale 1ns / 1ps
module mfb_fifo import mfb_pkg::*; #(
	parameter int W  = 8,
	parameter int AW = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int DEPTH = 1 << AW;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW:0]  wr_q;
	logic [AW:0]  rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign dout  = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q[AW-1:0]] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("word pushed into full queue");

endmodule

/* hw/rtl/mfb_front.sv */
// Front end: takes payload words, tracks frame and length, issues commands.
`timescale 1ns / 1ps
module mfb_front import mfb_pkg::*; #(
	parameter int MAX_PAYLOAD = 1500
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t item,
	output logic     full,
	output logic     cmd_push,
	output cmd_t     cmd,
	input  logic     cmd_full
);

	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);

	logic          in_frame_q;
	logic [CW-1:0] count_q;
	logic          accept;
	logic          first;
	logic          keep;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign first  = !in_frame_q;
	assign keep   = first || (count_q < MAX_CNT);

	// dropped bytes that neither open nor close a frame produce nothing
	assign cmd_push  = accept && (keep || item.last_byte);
	assign cmd.data  = item.payload_byte;
	assign cmd.hdr   = first;
	assign cmd.keep  = keep;
	assign cmd.last  = item.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
		end else if (accept) begin
			in_frame_q <= !item.last_byte;
			if (item.last_byte) begin
				count_q <= '0;
			end else if (first) begin
				count_q <= CW'(1);
			end else if (keep) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) count_q <= MAX_CNT)
		else $error("payload count past maximum");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last_byte) |=> !in_frame_q)
		else $error("frame still open after last byte");

endmodule

/* hw/rtl/mfb_back.sv */
// Back end: expands commands into header, payload and FCS bytes with CRC.
`timescale 1ns / 1ps
module mfb_back import mfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	input  hdr_cfg_t  cfg,
	output logic      out_push,
	output out_word_t out_word,
	input  logic      out_full
);

	phase_t                phase_q;
	phase_t                phase_d;
	phase_t                cur;
	logic [HDR_IDX_W-1:0]  idx_q;
	logic [HDR_IDX_W-1:0]  idx_d;
	logic [31:0]           crc_q;
	logic [31:0]           crc_d;
	logic [31:0]           fcs;
	logic [7:0]            hdr_bytes [1 << HDR_IDX_W];
	logic                  go;

	always_comb begin
		for (int i = 0; i < (1 << HDR_IDX_W); i++) begin
			hdr_bytes[i] = 8'h00;
		end
		hdr_bytes[0] = cfg.ctrl_word[7:0];
		hdr_bytes[1] = cfg.ctrl_word[15:8];
		// duration bytes 2 and 3 stay zero
		for (int i = 0; i < 6; i++) begin
			hdr_bytes[4 + i]  = cfg.dest_address[8*i +: 8];
			hdr_bytes[10 + i] = cfg.own_address[8*i +: 8];
			hdr_bytes[16 + i] = cfg.third_address[8*i +: 8];
		end
		hdr_bytes[22] = cfg.sequence_number[7:0];
		hdr_bytes[23] = cfg.sequence_number[15:8];
	end

	assign go  = !cmd_empty && !out_full;
	assign fcs = ~crc_q;

	// a fresh command starts at its first non-empty section
	always_comb begin
		if (phase_q == PH_NEW) begin
			cur = cmd.hdr ? PH_HDR : (cmd.keep ? PH_PAY : PH_FCS);
		end else begin
			cur = phase_q;
		end
	end

	always_comb begin
		phase_d            = phase_q;
		idx_d              = idx_q;
		crc_d              = crc_q;
		cmd_pop            = 1'b0;
		out_push           = go;
		out_word.frame_byte = 8'h00;
		out_word.frame_end  = 1'b0;
		unique case (cur)
			PH_HDR: begin
				out_word.frame_byte = hdr_bytes[idx_q];
				crc_d = crc32_byte(crc_q, hdr_bytes[idx_q]);
				if (idx_q == HDR_IDX_W'(HDR_LEN - 1)) begin
					idx_d = '0;
					if (cmd.keep) begin
						phase_d = PH_PAY;
					end else if (cmd.last) begin
						phase_d = PH_FCS;
					end else begin
						phase_d = PH_NEW;
						cmd_pop = go;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					phase_d = PH_HDR;
				end
			end
			PH_PAY: begin
				out_word.frame_byte = cmd.data;
				crc_d = crc32_byte(crc_q, cmd.data);
				idx_d = '0;
				if (cmd.last) begin
					phase_d = PH_FCS;
				end else begin
					phase_d = PH_NEW;
					cmd_pop = go;
				end
			end
			PH_FCS: begin
				out_word.frame_byte = fcs[8*idx_q[1:0] +: 8];
				if (idx_q[1:0] == 2'd3) begin
					out_word.frame_end = 1'b1;
					crc_d   = CRC_INIT;
					idx_d   = '0;
					phase_d = PH_NEW;
					cmd_pop = go;
				end else begin
					idx_d   = idx_q + 1'b1;
					phase_d = PH_FCS;
				end
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NEW;
			idx_q   <= '0;
			crc_q   <= CRC_INIT;
		end else if (go) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
		end
	end

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> go)
		else $error("command popped while stalled");

	a_fcs_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_word.frame_end) |=> (crc_q == CRC_INIT && phase_q == PH_NEW))
		else $error("CRC not reinitialized after FCS");

endmodule

/* hw/rtl/mac_frame_builder_crc32_top.sv */
// Top level of the MAC frame builder: config registers, front, queues, back.
`timescale 1ns / 1ps
// Path: a word taken into an empty block is registered in the command queue, its first result
// in the result queue. Throughput: one result word per cycle from the back end while the
// result queue has room; a frame with N kept payload bytes gives N + 28 words (24 header,
// N payload, 4 FCS), so payload streams at one word per cycle; the input stalls when the command queue is full.
// Reset (arst_n low, async): queues empty, no open frame, CRC all ones, registers to
// defaults (broadcast destination and third address, frame control 0x2900).
module mac_frame_builder_crc32_top import mfb_pkg::*; #(
	parameter int MAX_PAYLOAD = 1500,
	parameter int CMD_AW      = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input queue side
	input  logic                   push,
	input  in_word_t               item,
	output logic                   full,
	// result queue side
	output logic                   empty,
	input  logic                   pop,
	output out_word_t              result,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	hdr_cfg_t  cfg_q;
	logic      cmd_push;
	cmd_t      cmd_in;
	logic      cmd_full;
	cmd_t      cmd_head;
	logic      cmd_empty;
	logic      cmd_pop;
	logic      out_push;
	out_word_t out_word;
	logic      out_full;

	// Config writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address     <= OWN_ADDR_RST;
			cfg_q.dest_address    <= DEST_ADDR_RST;
			cfg_q.third_address   <= THIRD_ADDR_RST;
			cfg_q.ctrl_word       <= FRAME_CTRL_RST;
			cfg_q.sequence_number <= SEQ_NUM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OWN_ADDR:   cfg_q.own_address     <= cfg_data;
				REG_DEST_ADDR:  cfg_q.dest_address    <= cfg_data;
				REG_THIRD_ADDR: cfg_q.third_address   <= cfg_data;
				REG_FRAME_CTRL: cfg_q.ctrl_word       <= cfg_data[15:0];
				REG_SEQ_NUM:    cfg_q.sequence_number <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Front: frame open/close tracking and oversize drop.
	mfb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	// Command queue decouples intake from byte emission.
	mfb_fifo #(
		.W  ($bits(cmd_t)),
		.AW (CMD_AW)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty)
	);

	// Back: header/payload/FCS sequencer with running CRC.
	mfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.out_push  (out_push),
		.out_word  (out_word),
		.out_full  (out_full)
	);

	// Two-entry result queue: lets the back end keep going while a word waits.
	mfb_fifo #(
		.W  ($bits(out_word_t)),
		.AW (1)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_word),
		.full   (out_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule

/* dv/mac_frame_builder_crc32_top_tb.sv */
// Self-checking testbench for the MAC frame builder: header, payload and CRC-32 FCS words.
`timescale 1ns / 1ps
module mac_frame_builder_crc32_top_tb;
	import mfb_pkg::*;

	// Kept payload limit per frame; bytes past it are dropped by the block.
	localparam int PAYLOAD_CAP = 1500;
	// Cycles allowed after the last expected word before a register write or the end.
	// Covers the path of a word through the command queue and the result queue.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_WORDS = 150;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_PCT = 14;
	// Register slots with no register behind them; writes there must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] ADDR_ZERO = 48'h0;

	typedef enum logic {
		ROW_WRITE,
		ROW_BYTE
	} row_kind_t;

	// One directed step: a register write, or a payload word. A word that opens a frame
	// may carry the header that has to go out, typed in by hand (pinned).
	typedef struct {
		row_kind_t              kind;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  data;
		in_word_t               word;
		bit                     pinned;
		hdr_cfg_t               hdr;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	in_word_t               item = '0;
	logic                   full;
	logic                   empty;
	logic                   pop = 1'b0;
	out_word_t              result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Shadow of the header registers and the frame state of the block.
	hdr_cfg_t    hdr_regs;
	logic        frame_open;
	logic [31:0] fcs_acc;
	int          kept_bytes;
	// Frame words still owed by the block, oldest first.
	out_word_t   frame_bytes_due[$];
	plan_row_t   plan[$];

	int errors = 0;
	// No idling on either side while set.
	bit steady = 1'b0;
	// Set by the sender to make the receiver hold off that many cycles.
	int hold_req = 0;

	mac_frame_builder_crc32_top #(
		.MAX_PAYLOAD(PAYLOAD_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic hdr_cfg_t hdr_of(input logic [47:0] own, input logic [47:0] dest,
			input logic [47:0] third, input logic [15:0] fc, input logic [15:0] seq);
		hdr_cfg_t h;
		h.own_address = own;
		h.dest_address = dest;
		h.third_address = third;
		h.ctrl_word = fc;
		h.sequence_number = seq;
		return h;
	endfunction

	// Reflected CRC-32, one byte, LSB first.
	function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
		return r;
	endfunction

	function automatic void emit(input logic [7:0] b, input logic fin, input bit into_fcs);
		out_word_t w;
		w.frame_byte = b;
		w.frame_end = fin;
		frame_bytes_due.push_back(w);
		if (into_fcs) fcs_acc = crc_feed(fcs_acc, b);
	endfunction

	// Words the block owes for one accepted payload word; h is the header source.
	function automatic void shape_frame_bytes(input in_word_t w, input hdr_cfg_t h);
		logic [7:0]  hdr [HDR_LEN];
		logic [31:0] fcs;
		int          i;
		if (!frame_open) begin
			// fc lo/hi, duration 0, dest, own, third, seq lo/hi
			hdr[0] = h.ctrl_word[7:0];
			hdr[1] = h.ctrl_word[15:8];
			hdr[2] = 8'h00;
			hdr[3] = 8'h00;
			for (i = 0; i < 6; i++) begin
				hdr[4 + i] = h.dest_address[8*i +: 8];
				hdr[10 + i] = h.own_address[8*i +: 8];
				hdr[16 + i] = h.third_address[8*i +: 8];
			end
			hdr[22] = h.sequence_number[7:0];
			hdr[23] = h.sequence_number[15:8];
			fcs_acc = CRC_INIT;
			kept_bytes = 0;
			for (i = 0; i < HDR_LEN; i++) emit(hdr[i], 1'b0, 1'b1);
			frame_open = 1'b1;
		end
		// oversize bytes: no word, no CRC, but last still closes the frame
		if (kept_bytes < PAYLOAD_CAP) begin
			emit(w.payload_byte, 1'b0, 1'b1);
			kept_bytes++;
		end
		if (w.last_byte) begin
			fcs = ~fcs_acc;
			emit(fcs[7:0], 1'b0, 1'b0);
			emit(fcs[15:8], 1'b0, 1'b0);
			emit(fcs[23:16], 1'b0, 1'b0);
			emit(fcs[31:24], 1'b1, 1'b0);
			frame_open = 1'b0;
			fcs_acc = CRC_INIT;
			kept_bytes = 0;
		end
	endfunction

	function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		r.word = '0;
		r.pinned = 1'b0;
		r.hdr = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_byte(input logic [7:0] b, input logic fin, input bit pinned,
			input hdr_cfg_t h);
		plan_row_t r;
		r.kind = ROW_BYTE;
		r.idx = '0;
		r.data = '0;
		r.word.payload_byte = b;
		r.word.last_byte = fin;
		r.pinned = pinned;
		r.hdr = h;
		plan.push_back(r);
	endfunction

	// Offer one payload word, with random idle cycles ahead of it, until it is taken.
	task automatic send_word(input in_word_t w, input hdr_cfg_t h);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		shape_frame_bytes(w, h);
	endtask

	// Stop offering words until every owed word is out and the block has settled.
	task automatic drain();
		push <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_OWN_ADDR: hdr_regs.own_address = val;
			REG_DEST_ADDR: hdr_regs.dest_address = val;
			REG_THIRD_ADDR: hdr_regs.third_address = val;
			REG_FRAME_CTRL: hdr_regs.ctrl_word = val[15:0];
			REG_SEQ_NUM: hdr_regs.sequence_number = val[15:0];
			default: ;
		endcase
	endtask

	// Receiver: checks each popped word against the oldest owed word, then decides pop.
	initial begin
		int        hold_left;
		out_word_t want;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (frame_bytes_due.size() == 0) begin
					$error("unexpected word: frame_byte %02h frame_end %0b",
						result.frame_byte, result.frame_end);
					errors++;
				end else begin
					want = frame_bytes_due.pop_front();
					if (result.frame_byte !== want.frame_byte) begin
						$error("frame_byte: expected %02h, got %02h",
							want.frame_byte, result.frame_byte);
						errors++;
					end
					if (result.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b",
							want.frame_end, result.frame_end);
						errors++;
					end
				end
			end
			// long hold-off is counted here, not by the sender
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Sender: reset, directed table, oversize frame, back-pressure frame, random frames.
	initial begin
		in_word_t    w;
		hdr_cfg_t    dflt;
		hdr_cfg_t    ext;
		hdr_cfg_t    none;
		logic [63:0] r64;
		int          n;
		int          len;
		int          sent;

		hdr_regs = hdr_of(OWN_ADDR_RST, DEST_ADDR_RST, THIRD_ADDR_RST,
			FRAME_CTRL_RST, SEQ_NUM_RST);
		frame_open = 1'b0;
		fcs_acc = CRC_INIT;
		kept_bytes = 0;
		none = '0;
		// header after reset: fc 0x2900, broadcast dest and third, own 0, seq 0
		dflt = hdr_of(ADDR_ZERO, ADDR_ONES, ADDR_ONES, 16'h2900, 16'h0000);
		// every register at its other extreme; wide data is cut to 16 bits for fc and seq
		ext = hdr_of(ADDR_ONES, ADDR_ZERO, ADDR_ZERO, 16'hFFFF, 16'hFFFF);

		// Directed table. Pinned rows open a frame with a header read straight off
		// the register values; the FCS and the rest always come from the predictor.
		plan_byte(8'h00, 1'b0, 1'b1, dflt);
		plan_byte(8'hFF, 1'b1, 1'b0, none);
		// one-byte frame, CRC must restart
		plan_byte(8'hA5, 1'b1, 1'b1, dflt);
		plan_write(REG_OWN_ADDR, ADDR_ONES);
		plan_write(REG_DEST_ADDR, ADDR_ZERO);
		plan_write(REG_THIRD_ADDR, ADDR_ZERO);
		plan_write(REG_FRAME_CTRL, ADDR_ONES);
		plan_write(REG_SEQ_NUM, ADDR_ONES);
		plan_byte(8'h5A, 1'b1, 1'b1, ext);
		// writes to empty slots change nothing
		plan_write(REG_UNUSED_LO, 48'h1234_5678_9ABC);
		plan_write(REG_UNUSED_HI, ADDR_ONES);
		plan_byte(8'h01, 1'b0, 1'b1, ext);
		plan_byte(8'h80, 1'b0, 1'b0, none);
		// writes with a frame open only reach the next header
		plan_write(REG_OWN_ADDR, ADDR_ZERO);
		plan_write(REG_FRAME_CTRL, 48'h0);
		plan_byte(8'h7F, 1'b1, 1'b0, none);
		plan_byte(8'h3C, 1'b1, 1'b1,
			hdr_of(ADDR_ZERO, ADDR_ZERO, ADDR_ZERO, 16'h0000, 16'hFFFF));
		plan_write(REG_OWN_ADDR, 48'h0123_4567_89AB);
		plan_write(REG_DEST_ADDR, 48'hA1B2_C3D4_E5F6);
		plan_write(REG_THIRD_ADDR, 48'h5A5A_A5A5_0FF0);
		plan_write(REG_FRAME_CTRL, 48'h0208);
		plan_write(REG_SEQ_NUM, 48'h1230);
		plan_byte(8'h12, 1'b0, 1'b0, none);
		plan_byte(8'h34, 1'b0, 1'b0, none);
		plan_byte(8'h56, 1'b1, 1'b0, none);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_word(plan[i].word, plan[i].pinned ? plan[i].hdr : hdr_regs);
			end
		end

		// Oversize frame, no idling anywhere: the bytes past the cap are dropped,
		// the last flag still closes the frame.
		steady = 1'b1;
		for (n = 0; n < PAYLOAD_CAP + 4; n++) begin
			w.payload_byte = 8'($urandom_range(255));
			w.last_byte = (n == PAYLOAD_CAP + 3);
			send_word(w, hdr_regs);
		end
		steady = 1'b0;

		// Receiver holds off while the sender keeps offering; the block fills and stalls.
		drain();
		hold_req = HOLD_CYCLES;
		for (n = 0; n < 48; n++) begin
			w.payload_byte = 8'($urandom_range(255));
			w.last_byte = (n == 47);
			send_word(w, hdr_regs);
		end

		// Random frames, mostly short; register writes between and inside frames.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(4) == 0) begin
				r64 = {$urandom(), $urandom()};
				write_reg(CFG_INDEX_W'($urandom_range(7)), r64[CFG_DATA_W-1:0]);
			end else if ($urandom_range(9) == 0) begin
				drain();
			end
			len = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
			for (n = 0; n < len; n++) begin
				if (n != 0 && $urandom_range(49) == 0) begin
					r64 = {$urandom(), $urandom()};
					write_reg(CFG_INDEX_W'($urandom_range(7)), r64[CFG_DATA_W-1:0]);
				end
				w.payload_byte = 8'($urandom_range(255));
				w.last_byte = (n == len - 1);
				send_word(w, hdr_regs);
			end
			sent += len;
		end

		drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
